// ===== hw/rtl/dllm_pkg.sv =====
// Package for the doubly linked list manager.
// Holds opcodes, field widths, request and response payload types and parameter defaults.
// No dependencies.
package dllm_pkg;

   localparam int OPCODE_W = 3;
   localparam int SLOT_W   = 4;
   localparam int DATA_W   = 64;
   localparam int COUNT_W  = 5;

   localparam int NODE_SLOTS_DEFAULT  = 16;
   localparam int VALUE_WIDTH_DEFAULT = 64;

   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_DEL_FIRST  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DEL_LAST   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_UNLINK     = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_PEEK       = 3'd5;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic [SLOT_W-1:0]        slot_index;
      logic signed [DATA_W-1:0] slot_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic [COUNT_W-1:0]       entry_count;
      logic                     status;
   } rsp_type;

endpackage

// ===== hw/rtl/dllm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module dllm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dllm_core.sv =====
// List engine: head, tail and count registers, the sequencer and the value and link RAMs.
// Depends on dllm_pkg and dllm_ram.
module dllm_core #(
   parameter int NODE_SLOTS  = dllm_pkg::NODE_SLOTS_DEFAULT,
   parameter int VALUE_WIDTH = dllm_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dllm_pkg::req_type req_data,
   output logic              done_valid,
   input  logic              done_take,
   output dllm_pkg::rsp_type done_data
);
   import dllm_pkg::*;

   localparam int IDX_W  = $clog2(NODE_SLOTS);
   localparam int PTR_W  = $clog2(NODE_SLOTS + 1);
   localparam int SEL_W  = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;
   localparam int CNTX_W = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
   localparam logic [PTR_W-1:0] NONE = PTR_W'(NODE_SLOTS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LINK  = 2'd1;
   localparam logic [1:0] ST_VALUE = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [PTR_W-1:0]       count_ff, count_in;
   logic [NODE_SLOTS-1:0]  linked_ff, linked_in;
   logic [VALUE_WIDTH-1:0] head_val_ff, head_val_in;
   logic [VALUE_WIDTH-1:0] tail_val_ff, tail_val_in;
   logic [PTR_W-1:0]       target_ff, target_in;
   logic                   fix_head_ff, fix_head_in;
   logic                   status_ff, status_in;

   logic                   accept;
   logic                   empty;
   logic [SEL_W-1:0]       slot_wide;
   logic                   slot_ok;
   logic [PTR_W-1:0]       slot_ptr;
   logic                   is_push;
   logic                   push_ok;
   logic [PTR_W-1:0]       tgt_ptr;
   logic                   tgt_ok;
   logic [VALUE_WIDTH-1:0] new_value;
   logic [PTR_W-1:0]       prev_nb;
   logic [PTR_W-1:0]       next_nb;
   logic                   need_head;
   logic                   need_tail;

   logic                   next_we, prev_we, value_we;
   logic [IDX_W-1:0]       next_waddr, prev_waddr, value_waddr;
   logic [PTR_W-1:0]       next_wdata, prev_wdata;
   logic [IDX_W-1:0]       link_raddr, value_raddr;
   logic [PTR_W-1:0]       next_rdata, prev_rdata;
   logic [VALUE_WIDTH-1:0] value_rdata;
   logic [CNTX_W-1:0]      count_wide;

   dllm_ram #(.WIDTH(PTR_W), .DEPTH(NODE_SLOTS)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_waddr), .wr_data(next_wdata),
      .rd_addr(link_raddr), .rd_data(next_rdata)
   );

   dllm_ram #(.WIDTH(PTR_W), .DEPTH(NODE_SLOTS)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_waddr), .wr_data(prev_wdata),
      .rd_addr(link_raddr), .rd_data(prev_rdata)
   );

   dllm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(NODE_SLOTS)) u_value_ram (
      .clock(clock), .wr_en(value_we), .wr_addr(value_waddr), .wr_data(new_value),
      .rd_addr(value_raddr), .rd_data(value_rdata)
   );

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign empty     = (count_ff == '0);
   assign slot_wide = SEL_W'(req_data.slot_index);
   assign slot_ok   = (slot_wide < SEL_W'(NODE_SLOTS));
   assign slot_ptr  = PTR_W'(slot_wide);
   assign new_value = req_data.slot_value[VALUE_WIDTH-1:0];
   assign is_push   = (req_data.opcode == OP_PUSH_BACK) || (req_data.opcode == OP_PUSH_FRONT);
   assign push_ok   = is_push && slot_ok && !linked_ff[slot_ptr[IDX_W-1:0]];

   always_comb begin
      tgt_ptr = slot_ptr;
      tgt_ok  = 1'b0;
      case (req_data.opcode)
         OP_DEL_FIRST: begin
            tgt_ptr = head_ff;
            tgt_ok  = !empty;
         end
         OP_DEL_LAST: begin
            tgt_ptr = tail_ff;
            tgt_ok  = !empty;
         end
         OP_UNLINK: begin
            tgt_ptr = slot_ptr;
            tgt_ok  = !empty && slot_ok && linked_ff[slot_ptr[IDX_W-1:0]];
         end
         default: begin
            tgt_ptr = slot_ptr;
            tgt_ok  = 1'b0;
         end
      endcase
   end

   assign link_raddr = tgt_ptr[IDX_W-1:0];
   assign prev_nb    = (target_ff == head_ff) ? NONE : prev_rdata;
   assign next_nb    = (target_ff == tail_ff) ? NONE : next_rdata;
   assign need_head  = (target_ff == head_ff) && (next_nb != NONE);
   assign need_tail  = (target_ff == tail_ff) && (prev_nb != NONE);
   assign value_raddr = need_head ? next_nb[IDX_W-1:0] : prev_nb[IDX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      linked_in   = linked_ff;
      head_val_in = head_val_ff;
      tail_val_in = tail_val_ff;
      target_in   = target_ff;
      fix_head_in = fix_head_ff;
      status_in   = status_ff;
      next_we     = 1'b0;
      prev_we     = 1'b0;
      value_we    = 1'b0;
      next_waddr  = slot_ptr[IDX_W-1:0];
      prev_waddr  = slot_ptr[IDX_W-1:0];
      value_waddr = slot_ptr[IDX_W-1:0];
      next_wdata  = slot_ptr;
      prev_wdata  = slot_ptr;
      done_valid  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = (!is_push && empty) ? STATUS_EMPTY : STATUS_DONE;
               target_in = tgt_ptr;
               state_in  = ST_DONE;
               if (push_ok) begin
                  value_we = 1'b1;
                  linked_in[slot_ptr[IDX_W-1:0]] = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (req_data.opcode == OP_PUSH_BACK) begin
                     prev_we    = 1'b1;
                     prev_wdata = tail_ff;
                     next_we    = (tail_ff != NONE);
                     next_waddr = tail_ff[IDX_W-1:0];
                     next_wdata = slot_ptr;
                     tail_in     = slot_ptr;
                     tail_val_in = new_value;
                     if (empty) begin
                        head_in     = slot_ptr;
                        head_val_in = new_value;
                     end
                  end else begin
                     next_we    = 1'b1;
                     next_wdata = head_ff;
                     prev_we    = (head_ff != NONE);
                     prev_waddr = head_ff[IDX_W-1:0];
                     prev_wdata = slot_ptr;
                     head_in     = slot_ptr;
                     head_val_in = new_value;
                     if (empty) begin
                        tail_in     = slot_ptr;
                        tail_val_in = new_value;
                     end
                  end
               end else if (tgt_ok) begin
                  state_in = ST_LINK;
               end
            end
         end
         ST_LINK: begin
            next_we    = (prev_nb != NONE);
            next_waddr = prev_nb[IDX_W-1:0];
            next_wdata = next_nb;
            prev_we    = (next_nb != NONE);
            prev_waddr = next_nb[IDX_W-1:0];
            prev_wdata = prev_nb;
            if (target_ff == head_ff) begin
               head_in = next_nb;
            end
            if (target_ff == tail_ff) begin
               tail_in = prev_nb;
            end
            linked_in[target_ff[IDX_W-1:0]] = 1'b0;
            count_in    = count_ff - 1'b1;
            fix_head_in = need_head;
            state_in    = (need_head || need_tail) ? ST_VALUE : ST_DONE;
         end
         ST_VALUE: begin
            if (fix_head_ff) begin
               head_val_in = value_rdata;
            end else begin
               tail_val_in = value_rdata;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            done_valid = 1'b1;
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= NONE;
         tail_ff   <= NONE;
         count_ff  <= '0;
         linked_ff <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         linked_ff <= linked_in;
      end
      head_val_ff <= head_val_in;
      tail_val_ff <= tail_val_in;
      target_ff   <= target_in;
      fix_head_ff <= fix_head_in;
      status_ff   <= status_in;
   end

   assign count_wide = CNTX_W'(count_ff);

   always_comb begin
      done_data.front_value = (head_ff == NONE) ? '0 : DATA_W'($signed(head_val_ff));
      done_data.back_value  = (tail_ff == NONE) ? '0 : DATA_W'($signed(tail_val_ff));
      done_data.entry_count = count_wide[COUNT_W-1:0];
      done_data.status      = status_ff;
   end

`ifndef NO_ASSERTIONS
   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (head_ff == NONE))
      else $error("head pointer disagrees with count");

   a_tail_matches_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (tail_ff == NONE))
      else $error("tail pointer disagrees with count");

   a_linked_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(linked_ff) == int'(count_ff))
      else $error("linked bits disagree with count");

   a_push_finishes: assert property (@(posedge clock) disable iff (reset)
      accept && is_push |=> state_ff == ST_DONE)
      else $error("push request did not finish in one cycle");

   a_value_after_link: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_VALUE |-> $past(state_ff) == ST_LINK)
      else $error("value fetch without link update");
`endif

endmodule

// ===== hw/rtl/doubly_linked_list_manager_unit.sv =====
// Top level of the doubly linked list manager: list engine plus response output register.
// Depends on dllm_pkg, dllm_core and dllm_ram.
//
//  Channel  Ports                          Direction  Payload
//  request  req_valid, req_stall, req_data  in         dllm_pkg::req_type
//  response rsp_valid, rsp_stall, rsp_data  out        dllm_pkg::rsp_type
//
// Pushes, peeks and requests that change nothing go from ST_IDLE straight to ST_DONE.
// Deletes and unlinks pass through ST_LINK, and also ST_VALUE when the head or tail moves
// to a surviving neighbour, whose value is read from the value RAM after the link RAM read.
// Reset is synchronous; the list comes up empty without a clearing pass.
// The output register lets the next request run while a response is stalled.
module doubly_linked_list_manager_unit #(
   parameter int NODE_SLOTS  = dllm_pkg::NODE_SLOTS_DEFAULT,
   parameter int VALUE_WIDTH = dllm_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dllm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dllm_pkg::rsp_type rsp_data
);
   import dllm_pkg::*;

   logic    done_valid;
   logic    done_take;
   rsp_type done_data;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   dllm_core #(.NODE_SLOTS(NODE_SLOTS), .VALUE_WIDTH(VALUE_WIDTH)) u_core (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .done_valid(done_valid),
      .done_take(done_take),
      .done_data(done_data)
   );

   assign done_take = done_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (done_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== dv/doubly_linked_list_manager_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for doubly_linked_list_manager_unit: directed and random list requests,
// predicted in-bench and compared field by field. Depends on dllm_pkg and the unit under test.
module doubly_linked_list_manager_unit_tb;
   import dllm_pkg::*;

   localparam int SLOTS = NODE_SLOTS_DEFAULT;
   localparam logic [4:0] NONE_LINK = 5'd16;
   localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 360;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_req[$];
   rsp_type awaited_rsp[$];
   rsp_type seen_exp;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      mismatches = 0;
   int      idle_cycles = 0;

   logic signed [DATA_W-1:0] node_value [SLOTS];
   logic [4:0]               node_next [SLOTS];
   logic [4:0]               node_prev [SLOTS];
   logic [SLOTS-1:0]         linked_mask;
   logic [4:0]               head_idx;
   logic [4:0]               tail_idx;
   logic [COUNT_W-1:0]       live_count;

   int               gen_order[$];
   logic [SLOTS-1:0] gen_mask = '0;

   doubly_linked_list_manager_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void attach_node(logic [3:0] s, logic signed [DATA_W-1:0] v, bit at_back);
      if (linked_mask[s] || live_count >= SLOTS) return;
      node_value[s] = v;
      linked_mask[s] = 1'b1;
      if (at_back) begin
         node_prev[s] = tail_idx;
         node_next[s] = NONE_LINK;
         if (tail_idx != NONE_LINK) node_next[tail_idx[3:0]] = {1'b0, s};
         else head_idx = {1'b0, s};
         tail_idx = {1'b0, s};
      end else begin
         node_next[s] = head_idx;
         node_prev[s] = NONE_LINK;
         if (head_idx != NONE_LINK) node_prev[head_idx[3:0]] = {1'b0, s};
         else tail_idx = {1'b0, s};
         head_idx = {1'b0, s};
      end
      live_count = live_count + 1'b1;
   endfunction

   function automatic void detach_node(logic [3:0] s);
      logic [4:0] p;
      logic [4:0] n;
      if (!linked_mask[s]) return;
      p = node_prev[s];
      n = node_next[s];
      if (p != NONE_LINK) node_next[p[3:0]] = n;
      else head_idx = n;
      if (n != NONE_LINK) node_prev[n[3:0]] = p;
      else tail_idx = p;
      linked_mask[s] = 1'b0;
      if (live_count > 0) live_count = live_count - 1'b1;
   endfunction

   function automatic rsp_type list_apply(req_type r);
      rsp_type o;
      logic    was_empty;
      o = '0;
      was_empty = (live_count == 0);
      o.status = STATUS_DONE;
      case (r.opcode)
         OP_PUSH_BACK: attach_node(r.slot_index, r.slot_value, 1'b1);
         OP_PUSH_FRONT: attach_node(r.slot_index, r.slot_value, 1'b0);
         OP_DEL_FIRST: begin
            if (was_empty) o.status = STATUS_EMPTY;
            else detach_node(head_idx[3:0]);
         end
         OP_DEL_LAST: begin
            if (was_empty) o.status = STATUS_EMPTY;
            else detach_node(tail_idx[3:0]);
         end
         OP_UNLINK: begin
            if (was_empty) o.status = STATUS_EMPTY;
            else detach_node(r.slot_index);
         end
         default: begin
            if (was_empty) o.status = STATUS_EMPTY;
         end
      endcase
      o.front_value = (head_idx != NONE_LINK) ? node_value[head_idx[3:0]] : '0;
      o.back_value = (tail_idx != NONE_LINK) ? node_value[tail_idx[3:0]] : '0;
      o.entry_count = live_count;
      return o;
   endfunction

   task automatic note_mismatch(string tag, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected front %0d back %0d count %0d status %0d",
                  tag, want.front_value, want.back_value, want.entry_count, want.status);
         $display("%s: got front %0d back %0d count %0d status %0d",
                  tag, got.front_value, got.back_value, got.entry_count, got.status);
      end
   endtask

   // Queues one request and keeps the generator's own view of the list order in step.
   task automatic add_req(logic [OPCODE_W-1:0] op, int slot, logic signed [DATA_W-1:0] v);
      req_type r;
      int      k;
      r.opcode = op;
      r.slot_index = slot[SLOT_W-1:0];
      r.slot_value = v;
      pending_req.insert(pending_req.size(), r);
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (!gen_mask[slot]) begin
               gen_mask[slot] = 1'b1;
               if (op == OP_PUSH_BACK) gen_order.insert(gen_order.size(), slot);
               else gen_order.insert(0, slot);
            end
         end
         OP_DEL_FIRST: begin
            if (gen_order.size() > 0) gen_mask[gen_order.pop_front()] = 1'b0;
         end
         OP_DEL_LAST: begin
            if (gen_order.size() > 0) gen_mask[gen_order.pop_back()] = 1'b0;
         end
         OP_UNLINK: begin
            for (k = 0; k < gen_order.size(); k++) begin
               if (gen_order[k] == slot) begin
                  gen_order.delete(k);
                  gen_mask[slot] = 1'b0;
                  break;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Mostly well-formed traffic: pushes of free slots and unlinks of linked ones, with the push
   // share swinging between filling and emptying so that both the full and empty list are reached.
   task automatic queue_random(int n);
      int                       i;
      int                       roll;
      int                       slot;
      int                       push_pct;
      logic [OPCODE_W-1:0]      op;
      logic signed [DATA_W-1:0] v;
      for (i = 0; i < n; i++) begin
         push_pct = ((i / 48) % 2 == 0) ? 70 : 25;
         slot = $urandom_range(SLOTS - 1);
         roll = $urandom_range(99);
         if (roll < push_pct) begin
            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            if (gen_mask != '1 && $urandom_range(9) != 0) begin
               while (gen_mask[slot]) slot = $urandom_range(SLOTS - 1);
            end
         end else begin
            roll = $urandom_range(99);
            if (roll < 40) begin
               op = OP_UNLINK;
               if (gen_order.size() > 0 && $urandom_range(7) != 0)
                  slot = gen_order[$urandom_range(gen_order.size() - 1)];
            end else if (roll < 60) op = OP_DEL_FIRST;
            else if (roll < 80) op = OP_DEL_LAST;
            else if (roll < 92) op = OP_PEEK;
            else op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
         end
         case ($urandom_range(15))
            0: v = 64'sh7FFF_FFFF_FFFF_FFFF;
            1: v = 64'sh8000_0000_0000_0000;
            2: v = '0;
            3: v = -64'sd1;
            default: v = {$urandom, $urandom};
         endcase
         add_req(op, slot, v);
      end
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || req_valid || awaited_rsp.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         head_idx = NONE_LINK;
         tail_idx = NONE_LINK;
         live_count = '0;
         linked_mask = '0;
      end else begin
         if (req_valid && !req_stall)
            awaited_rsp.insert(awaited_rsp.size(), list_apply(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_req.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_req.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               note_mismatch("unexpected response", '0, rsp_data);
            end else begin
               seen_exp = awaited_rsp.pop_front();
               if (rsp_data.front_value !== seen_exp.front_value ||
                   rsp_data.back_value !== seen_exp.back_value ||
                   rsp_data.entry_count !== seen_exp.entry_count ||
                   rsp_data.status !== seen_exp.status)
                  note_mismatch("response mismatch", seen_exp, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int ph;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty list: every delete, unlink and peek form, including the spare opcodes.
      add_req(OP_PEEK, 0, '0);
      add_req(OP_DEL_FIRST, 0, '0);
      add_req(OP_DEL_LAST, 15, '0);
      add_req(OP_UNLINK, 0, '0);
      add_req(OP_SPARE_A, 0, '0);
      add_req(OP_SPARE_B, 15, -64'sd1);
      // Push front onto an empty list, then both ends with the value extremes.
      add_req(OP_PUSH_FRONT, 5, 64'sh7FFF_FFFF_FFFF_FFFF);
      add_req(OP_PUSH_BACK, 0, 64'sh8000_0000_0000_0000);
      add_req(OP_PUSH_BACK, 15, -64'sd1);
      add_req(OP_PUSH_FRONT, 3, '0);
      // A push of a slot that is already linked and an unlink of one that is not.
      add_req(OP_PUSH_BACK, 5, 64'sd123);
      add_req(OP_UNLINK, 9, '0);
      // Unlinking the head, the tail and a middle slot.
      add_req(OP_UNLINK, 3, '0);
      add_req(OP_UNLINK, 15, '0);
      add_req(OP_PUSH_BACK, 15, 64'sh0123_4567_89AB_CDEF);
      add_req(OP_PUSH_FRONT, 3, 64'shFEDC_BA98_7654_3210);
      add_req(OP_UNLINK, 0, '0);
      add_req(OP_PEEK, 7, '0);
      add_req(OP_SPARE_B, 2, '0);
      add_req(OP_DEL_FIRST, 0, '0);
      add_req(OP_DEL_LAST, 0, '0);
      add_req(OP_DEL_FIRST, 0, '0);
      add_req(OP_DEL_LAST, 0, '0);
      add_req(OP_PEEK, 0, '0);
      wait_drained();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 86; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 86; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         queue_random(PHASE_ITEMS / 2);
         wait_drained();
         queue_random(PHASE_ITEMS / 2);
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dllm_pkg.sv
hw/rtl/dllm_ram.sv
hw/rtl/dllm_core.sv
hw/rtl/doubly_linked_list_manager_unit.sv
dv/doubly_linked_list_manager_unit_tb.sv
